/* hdl/tlbst_pkg.sv */
// ----------------------------------------------------------------------------
// tlbst_pkg
// Shared types and constants for the segmented translation block with TLB.
// ----------------------------------------------------------------------------
package tlbst_pkg;

    // Geometry of the block
    localparam int TLB_ENTRIES  = 16;   // power of two: index is a bit slice
    localparam int MAX_SEGS     = 6;
    localparam int NUM_CONTEXTS = 8;
    localparam int ADDR_BITS    = 16;

    // Derived widths
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int SEG_CELLS = NUM_CONTEXTS * MAX_SEGS;
    localparam int CELL_W    = $clog2(SEG_CELLS);
    localparam int CNT_W     = $clog2(MAX_SEGS + 1);
    localparam int CTX_W     = 3;
    localparam int SLOT_W    = 3;

    // Request kinds
    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_WRITE     = 1'b1;

    // Input word
    typedef struct packed {
        logic                 req_type;
        logic [CTX_W-1:0]     context_id;
        logic [ADDR_BITS-1:0] logical_addr;
        logic [SLOT_W-1:0]    seg_slot;
        logic [ADDR_BITS-1:0] seg_start;
        logic [ADDR_BITS-1:0] seg_len;
        logic [CNT_W-1:0]     seg_total;
    } req_t;

    // Result word
    typedef struct packed {
        logic [ADDR_BITS-1:0] phys_addr;
        logic                 tlb_hit;
        logic                 fault;
    } rsp_t;

    // One TLB line: tags and translation
    typedef struct packed {
        logic [ADDR_BITS-1:0] logical_tag;
        logic [CTX_W-1:0]     context_tag;
        logic [ADDR_BITS-1:0] phys;
    } tlb_entry_t;

    // One segment descriptor
    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] length;
    } seg_entry_t;

    // Access to the TLB memory
    typedef struct packed {
        logic                 we;
        logic [TLB_IDX_W-1:0] waddr;
        tlb_entry_t           wdata;
        logic [TLB_IDX_W-1:0] raddr;
    } tlb_mem_req_t;

    // Access to the segment memory
    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] waddr;
        seg_entry_t        wdata;
        logic [CELL_W-1:0] raddr;
    } seg_mem_req_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_WALK,
        S_WRITE
    } state_t;

endpackage

/* hdl/tlbst_ram.sv */
// ----------------------------------------------------------------------------
// tlbst_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlbst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tlbst_ctrl.sv */
// ----------------------------------------------------------------------------
// tlbst_ctrl
// Request sequencer: TLB probe, segment walk, TLB fill and table writes.
// ----------------------------------------------------------------------------
module tlbst_ctrl
    import tlbst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  req_t         req,
    output logic         done,
    output rsp_t         result,
    output tlb_mem_req_t tlb_req,
    input  tlb_entry_t   tlb_rdata,
    output seg_mem_req_t seg_req,
    input  seg_entry_t   seg_rdata
);

    // Control state
    state_t                 state_reg, state_next;
    logic [TLB_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg [NUM_CONTEXTS];
    logic                   done_reg, done_next;

    // Latched request and walk payload
    req_t                   req_reg, req_next;
    logic [TLB_IDX_W-1:0]   idx_reg, idx_next;
    logic [ADDR_BITS-1:0]   rem_reg, rem_next;
    logic [CELL_W-1:0]      cell_reg, cell_next;
    logic [CNT_W-1:0]       seg_idx_reg, seg_idx_next;
    logic [CNT_W-1:0]       seg_cnt_reg, seg_cnt_next;
    rsp_t                   rsp_reg, rsp_next;

    // Helpers
    logic                   accept;
    logic [TLB_IDX_W-1:0]   in_idx;
    logic                   ctx_ok;
    logic                   tag_match;
    logic [CELL_W-1:0]      ctx_cell_base;
    logic [ADDR_BITS:0]     phys_sum;
    logic                   fits;
    logic                   slot_ok;
    logic [CNT_W-1:0]       total_sat;
    logic                   count_we;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    // TLB index of the incoming word
    assign in_idx = req.logical_addr[TLB_IDX_W-1:0]
                  ^ TLB_IDX_W'({{(ADDR_BITS - CTX_W){1'b0}}, req.context_id});

    assign ctx_ok        = int'(req_reg.context_id) < NUM_CONTEXTS;
    assign tag_match     = valid_reg[idx_reg]
                        && (tlb_rdata.logical_tag == req_reg.logical_addr)
                        && (tlb_rdata.context_tag == req_reg.context_id);
    assign ctx_cell_base = CELL_W'(int'(req_reg.context_id) * MAX_SEGS);
    assign phys_sum      = {1'b0, seg_rdata.base} + {1'b0, rem_reg};
    assign fits          = rem_reg < seg_rdata.length;
    assign slot_ok       = int'(req_reg.seg_slot) < MAX_SEGS;
    assign total_sat     = (int'(req_reg.seg_total) > MAX_SEGS) ? CNT_W'(MAX_SEGS)
                                                                 : req_reg.seg_total;

    // Next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        req_next     = req_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        cell_next    = cell_reg;
        seg_idx_next = seg_idx_reg;
        seg_cnt_next = seg_cnt_reg;
        rsp_next     = rsp_reg;
        count_we     = 1'b0;

        tlb_req.we          = 1'b0;
        tlb_req.waddr       = idx_reg;
        tlb_req.wdata       = '{logical_tag: req_reg.logical_addr,
                                context_tag: req_reg.context_id,
                                phys:        phys_sum[ADDR_BITS-1:0]};
        tlb_req.raddr       = in_idx;
        seg_req.we          = 1'b0;
        seg_req.waddr       = CELL_W'(int'(req_reg.context_id) * MAX_SEGS
                                      + int'(req_reg.seg_slot));
        seg_req.wdata       = '{base: req_reg.seg_start, length: req_reg.seg_len};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    idx_next = in_idx;
                    rem_next = req.logical_addr;
                    if (req.req_type == REQ_WRITE)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                // Hit, fault or start the walk at the context's first segment
                cell_next    = ctx_cell_base;
                seg_idx_next = '0;
                if (ctx_ok)
                begin
                    seg_cnt_next = count_reg[req_reg.context_id];
                end
                else
                begin
                    seg_cnt_next = '0;
                end
                if (ctx_ok && tag_match)
                begin
                    rsp_next   = '{phys_addr: tlb_rdata.phys, tlb_hit: 1'b1, fault: 1'b0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!ctx_ok || count_reg[req_reg.context_id] == '0)
                begin
                    rsp_next   = '{phys_addr: '0, tlb_hit: 1'b0, fault: 1'b1};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // Test one segment per cycle, prefetch the next one
                cell_next    = cell_reg + CELL_W'(1);
                seg_idx_next = seg_idx_reg + CNT_W'(1);
                rem_next     = rem_reg - seg_rdata.length;
                if (fits)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (phys_sum[ADDR_BITS])
                    begin
                        rsp_next = '{phys_addr: '0, tlb_hit: 1'b0, fault: 1'b1};
                    end
                    else
                    begin
                        rsp_next = '{phys_addr: phys_sum[ADDR_BITS-1:0],
                                     tlb_hit: 1'b0, fault: 1'b0};
                        tlb_req.we          = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                    end
                end
                else if (seg_idx_reg + CNT_W'(1) == seg_cnt_reg)
                begin
                    rsp_next   = '{phys_addr: '0, tlb_hit: 1'b0, fault: 1'b1};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WRITE:
            begin
                // For a valid context, commit the count, commit the descriptor (valid slot only) and flush the TLB
                if (ctx_ok)
                begin
                    seg_req.we = slot_ok;
                    count_we   = 1'b1;
                    valid_next = '0;
                end
                rsp_next   = '{phys_addr: '0, tlb_hit: 1'b0, fault: 1'b0};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        seg_req.raddr = cell_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_CONTEXTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
            if (count_we)
            begin
                count_reg[req_reg.context_id] <= total_sat;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        rem_reg     <= rem_next;
        cell_reg    <= cell_next;
        seg_idx_reg <= seg_idx_next;
        seg_cnt_reg <= seg_cnt_next;
        rsp_reg     <= rsp_next;
    end

    // A result only follows a request in flight
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("result without a request in flight");

    // Hit and fault never together
    a_hit_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(rsp_reg.tlb_hit && rsp_reg.fault))
        else $error("result flags both hit and fault");

    // A fault carries a zero address
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.fault) |-> (rsp_reg.phys_addr == '0))
        else $error("fault with nonzero address");

    // A table write to a valid context leaves the TLB empty
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && $past(state_reg == S_WRITE) && $past(ctx_ok)) |-> (valid_reg == '0))
        else $error("TLB not flushed after table write");

    // TLB fills happen only during the walk
    a_fill_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tlb_req.we |-> (state_reg == S_WALK) && fits && !phys_sum[ADDR_BITS])
        else $error("TLB fill outside a successful walk");

endmodule

/* hdl/tlb_segment_translation.sv */
// ----------------------------------------------------------------------------
// tlb_segment_translation
// Segmented logical-to-physical translation behind a direct-mapped TLB.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Each word gives one
// result, shown for one cycle with done high; it cannot be held off, and the
// next word may be taken in the cycle the result is shown. A table write and
// a TLB hit need no walk; a miss walks the context's segment descriptors,
// examining 1 to 6 of them and reading one descriptor a cycle from the
// segment memory. A miss on a context with no segments faults without a walk.
// ----------------------------------------------------------------------------
module tlb_segment_translation
    import tlbst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t result
);

    tlb_mem_req_t tlb_req;
    tlb_entry_t   tlb_rdata;
    seg_mem_req_t seg_req;
    seg_entry_t   seg_rdata;

    // Sequencer
    tlbst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .tlb_req   (tlb_req),
        .tlb_rdata (tlb_rdata),
        .seg_req   (seg_req),
        .seg_rdata (seg_rdata)
    );

    // TLB tags and translations
    tlbst_ram #(
        .WIDTH ($bits(tlb_entry_t)),
        .DEPTH (TLB_ENTRIES)
    ) u_tlb_ram (
        .clk   (clk),
        .we    (tlb_req.we),
        .waddr (tlb_req.waddr),
        .wdata (tlb_req.wdata),
        .raddr (tlb_req.raddr),
        .rdata (tlb_rdata)
    );

    // Segment descriptors of all contexts
    tlbst_ram #(
        .WIDTH ($bits(seg_entry_t)),
        .DEPTH (SEG_CELLS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (seg_req.we),
        .waddr (seg_req.waddr),
        .wdata (seg_req.wdata),
        .raddr (seg_req.raddr),
        .rdata (seg_rdata)
    );

endmodule
